### rtl/mat_pkg.sv
// Shared constants and types for the moving-average trigger block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package mat_pkg;

  localparam int unsigned SampleBits = 10;
  localparam int unsigned Window     = 5;

  localparam int unsigned ThreshW = 10;
  localparam int unsigned BaseW   = 16;
  localparam int unsigned HoldW   = 18;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CmpW    = (SampleBits > ThreshW) ? SampleBits : ThreshW;

  localparam int unsigned SumMax = Window * ((1 << SampleBits) - 1);
  localparam int unsigned SumW   = $clog2(SumMax + 1);
  localparam int unsigned SlotW  = (Window > 1) ? $clog2(Window) : 1;

  localparam int unsigned DivShift = SumW + $clog2(Window);
  localparam int unsigned DivMul   = ((1 << DivShift) + Window - 1) / Window;
  localparam int unsigned DivMulW  = DivShift + 1;
  localparam int unsigned ProdW    = SumW + DivMulW;

  localparam int unsigned Band2 = 2 * Window * Window;
  localparam int unsigned Band3 = 3 * Window * Window;
  localparam int unsigned Band4 = 4 * Window * Window;

  localparam logic [ThreshW-1:0] ThreshReset  = ThreshW'(1);
  localparam logic [BaseW-1:0]   BaseReset    = BaseW'(1500);

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD    = CfgIdxW'(0),
    CFG_BASE_HOLDOFF = CfgIdxW'(1)
  } cfg_reg_e;

endpackage

### rtl/mat_if.sv
// Valid/ready channel interfaces for sample items, result items and register writes.
// Depends on mat_pkg.
`timescale 1ns / 1ps

interface mat_in_if;
  logic                            valid;
  logic                            ready;
  logic [mat_pkg::SampleBits-1:0]  sample;
  logic [mat_pkg::TimeW-1:0]       now_ms;

  modport source (output valid, sample, now_ms, input ready);
  modport sink   (input valid, sample, now_ms, output ready);
endinterface

interface mat_out_if;
  logic                            valid;
  logic                            ready;
  logic [mat_pkg::SampleBits-1:0]  level;
  logic                            trigger;

  modport source (output valid, level, trigger, input ready);
  modport sink   (input valid, level, trigger, output ready);
endinterface

interface mat_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mat_pkg::CfgIdxW-1:0]    index;
  logic [mat_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/moving_average_trigger_holdoff.sv
// Moving-average threshold detector with strength-scaled trigger hold-off.
// Depends on mat_pkg and the channel interfaces in mat_if.
`timescale 1ns / 1ps

// Usage:
//   in_i  : one item per sensor sample (sample, now_ms).
//   out_o : one item per input item (level, trigger), in input order.
//   cfg_i : register writes (index 0 threshold, 1 base hold-off in ms),
//           always ready; write only while the block is idle.
// Pipeline: an accepted item is captured in an input register; once the result
// register is free or being taken, the averaging ring, running sum and hold-off
// state are updated and the result register is loaded, and the result is offered
// from there until out_o takes it.
// Throughput: one item per cycle while out_o does not stall; the whole update is
// one pass of logic between the input register and the result register.
// Stall: while the result register waits on out_o.ready the input register
// holds, and in_i.ready drops only once both registers are full.
// Reset: clears the ring, running sum, slot pointer and last trigger time,
// sets the hold-off to 1500 ms, threshold to 1 and base hold-off to 1500.
module moving_average_trigger_holdoff (
  input  logic  clk_i,
  input  logic  rst_ni,
  mat_in_if.sink    in_i,
  mat_out_if.source out_o,
  mat_cfg_if.sink   cfg_i
);

  logic [mat_pkg::ThreshW-1:0]    thresh_q;
  logic [mat_pkg::BaseW-1:0]      base_q;

  logic                           s1_valid_q, s1_valid_d;
  logic [mat_pkg::SampleBits-1:0] s1_sample_q;
  logic [mat_pkg::TimeW-1:0]      s1_now_q;

  logic                           out_valid_q, out_valid_d;
  logic [mat_pkg::SampleBits-1:0] out_level_q;
  logic                           out_trig_q;

  logic [mat_pkg::SampleBits-1:0] ring_q [mat_pkg::Window];
  logic [mat_pkg::SumW-1:0]       sum_q, sum_d;
  logic [mat_pkg::SlotW-1:0]      slot_q, slot_d;
  logic [mat_pkg::TimeW-1:0]      last_q;
  logic [mat_pkg::HoldW-1:0]      hold_q, hold_d;

  logic                           in_acc;
  logic                           advance;
  logic [mat_pkg::ProdW-1:0]      prod;
  logic [mat_pkg::SampleBits-1:0] level;
  logic [mat_pkg::TimeW-1:0]      elapsed;
  logic                           fire;
  logic [mat_pkg::HoldW-1:0]      base_x1, base_x2, base_x3;

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid   = out_valid_q;
  assign out_o.level   = out_level_q;
  assign out_o.trigger = out_trig_q;

  always_comb begin
    sum_d   = sum_q - mat_pkg::SumW'(ring_q[slot_q]) + mat_pkg::SumW'(s1_sample_q);
    prod    = mat_pkg::ProdW'(sum_d) * mat_pkg::ProdW'(mat_pkg::DivMul);
    level   = mat_pkg::SampleBits'(prod >> mat_pkg::DivShift);
    elapsed = s1_now_q - last_q;
    fire    = (mat_pkg::CmpW'(level) >= mat_pkg::CmpW'(thresh_q)) &&
              (elapsed > mat_pkg::TimeW'(hold_q));

    base_x1 = mat_pkg::HoldW'(base_q);
    base_x2 = base_x1 << 1;
    base_x3 = base_x1 + base_x2;
    priority if (sum_d >= mat_pkg::SumW'(mat_pkg::Band4)) begin
      hold_d = base_x2;
    end else if (sum_d >= mat_pkg::SumW'(mat_pkg::Band3)) begin
      hold_d = base_x3;
    end else if (sum_d >= mat_pkg::SumW'(mat_pkg::Band2)) begin
      hold_d = base_x2;
    end else begin
      hold_d = base_x1;
    end

    if (slot_q == mat_pkg::SlotW'(mat_pkg::Window - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + mat_pkg::SlotW'(1);
    end

    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= mat_pkg::ThreshReset;
      base_q   <= mat_pkg::BaseReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mat_pkg::CFG_THRESHOLD:    thresh_q <= cfg_i.data[mat_pkg::ThreshW-1:0];
        mat_pkg::CFG_BASE_HOLDOFF: base_q   <= cfg_i.data[mat_pkg::BaseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      slot_q      <= '0;
      last_q      <= '0;
      hold_q      <= mat_pkg::HoldW'(mat_pkg::BaseReset);
      for (int i = 0; i < mat_pkg::Window; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        ring_q[slot_q] <= s1_sample_q;
        sum_q          <= sum_d;
        slot_q         <= slot_d;
        if (fire) begin
          last_q <= s1_now_q;
          hold_q <= hold_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= in_i.sample;
      s1_now_q    <= in_i.now_ms;
    end
    if (advance) begin
      out_level_q <= level;
      out_trig_q  <= fire;
    end
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= mat_pkg::SlotW'(mat_pkg::Window - 1))
    else $error("ring slot pointer out of range");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= mat_pkg::SumW'(mat_pkg::SumMax))
    else $error("running sum above window maximum");

  a_fire_records: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && fire |=> last_q == $past(s1_now_q))
    else $error("trigger time not recorded");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while both registers are full");

endmodule
